[src/line_circle_intersection_core_defines.svh]
// Assertion macros for the line/circle intersection core.
// Included by files that assert; depends on signals clk and rst_n in scope.
`ifndef LINE_CIRCLE_INTERSECTION_CORE_DEFINES_SVH
`define LINE_CIRCLE_INTERSECTION_CORE_DEFINES_SVH
`ifndef SYNTH
`define LCI_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lci check failed");
`define LCI_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lci check failed");
`else
`define LCI_CHECK(label, ante, cons)
`define LCI_CHECK_NEXT(label, ante, cons)
`endif
`endif

[src/lci_pkg.sv]
// Shared widths, count codes and queue item types for the intersection core.
// No dependencies.
package lci_pkg;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SQ_W    = 31;
  localparam int AI_W    = 34;
  localparam int E_W     = 68;
  localparam int Q_W     = 34;
  localparam int REM_W   = Q_W + 4;
  localparam int P_W     = 32;
  localparam int N_W     = 52;
  localparam int QUO_W   = 50;
  localparam int COORD_W = 17;
  localparam int COORD_MAX_MAG = 65535;
  localparam int COORD_MIN_MAG = 65536;
  localparam int DIV_LAT = QUO_W + 2;

  typedef enum logic [1:0] {
    CNT_NONE    = 2'd0,
    CNT_TANGENT = 2'd1,
    CNT_SECANT  = 2'd2
  } count_t;

  typedef struct packed {
    count_t                  cnt;
    logic signed [15:0]      sa;
    logic signed [15:0]      sb;
    logic [AI_W-1:0]         ai;
    logic signed [P_W-1:0]   p;
    logic [E_W-1:0]          e;
  } mid_item_t;

  typedef struct packed {
    count_t                    cnt;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } out_item_t;
endpackage

[src/lci_fifo.sv]
// Small register queue used between front and back and at the result side.
// Depends on nothing; width and depth are parameters.
module lci_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW:0]  wp_r, rp_r;

  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign rdata = mem[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r[AW-1:0]] <= wdata;
  end
endmodule

[src/lci_front.sv]
// Front pipeline: forms A, the a*b term and the exact discriminant, classifies count.
// Depends on lci_pkg.
module lci_front import lci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [15:0] in_sa,
  input  logic signed [15:0] in_sb,
  input  logic [15:0]        in_rr,
  output logic               out_valid,
  output mid_item_t          out_item
);
  localparam logic [AI_W-1:0] SCALE2 = AI_W'(1) << (2 * FRAC_BITS);

  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic signed [15:0] sa_a_r, sb_a_r, sa_b_r, sb_b_r, sa_c_r, sb_c_r;
  logic signed [15:0] sa_d_r, sb_d_r, sa_e_r, sb_e_r;
  logic [15:0] rr_a_r;
  logic [SQ_W-1:0] sa2_b_r, sb2_b_r;
  logic signed [P_W-1:0] p_b_r, p_c_r, p_d_r, p_e_r;
  logic [31:0] rr2_b_r, rr2_c_r;
  logic [AI_W-1:0] ai_c_r, ai_d_r, ai_e_r;
  logic [E_W-1:0] neg_c_r, neg_d_r, neg_e_r, pos_e_r;
  logic [48:0] pl_d_r, ph_d_r;
  mid_item_t item_f_r;

  logic signed [31:0] sa2_w, sb2_w, p_w;
  logic [E_W:0] diff_w;

  assign sa2_w  = sa_a_r * sa_a_r;
  assign sb2_w  = sb_a_r * sb_a_r;
  assign p_w    = sa_a_r * sb_a_r;
  assign diff_w = {1'b0, pos_e_r} - {1'b0, neg_e_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {va_r, vb_r, vc_r, vd_r, ve_r, vf_r} <= '0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_a_r  <= in_sa;
      sb_a_r  <= in_sb;
      rr_a_r  <= in_rr;
      sa_b_r  <= sa_a_r;
      sb_b_r  <= sb_a_r;
      sa2_b_r <= sa2_w[SQ_W-1:0];
      sb2_b_r <= sb2_w[SQ_W-1:0];
      p_b_r   <= p_w;
      rr2_b_r <= rr_a_r * rr_a_r;
      sa_c_r  <= sa_b_r;
      sb_c_r  <= sb_b_r;
      p_c_r   <= p_b_r;
      rr2_c_r <= rr2_b_r;
      ai_c_r  <= AI_W'(sa2_b_r) + SCALE2;
      neg_c_r <= E_W'(sb2_b_r) << (2 * FRAC_BITS);
      sa_d_r  <= sa_c_r;
      sb_d_r  <= sb_c_r;
      p_d_r   <= p_c_r;
      ai_d_r  <= ai_c_r;
      neg_d_r <= neg_c_r;
      pl_d_r  <= ai_c_r[16:0] * rr2_c_r;
      ph_d_r  <= ai_c_r[AI_W-1:17] * rr2_c_r;
      sa_e_r  <= sa_d_r;
      sb_e_r  <= sb_d_r;
      p_e_r   <= p_d_r;
      ai_e_r  <= ai_d_r;
      neg_e_r <= neg_d_r;
      pos_e_r <= (E_W'(ph_d_r) << 17) + E_W'(pl_d_r);
      item_f_r.sa <= sa_e_r;
      item_f_r.sb <= sb_e_r;
      item_f_r.p  <= p_e_r;
      item_f_r.ai <= ai_e_r;
      item_f_r.e  <= diff_w[E_W-1:0];
      if (diff_w[E_W])
        item_f_r.cnt <= CNT_NONE;
      else if (diff_w == '0)
        item_f_r.cnt <= CNT_TANGENT;
      else
        item_f_r.cnt <= CNT_SECANT;
    end
  end

  assign out_valid = vf_r;
  assign out_item  = item_f_r;
endmodule

[src/lci_div.sv]
// Pipelined signed divider, one quotient bit per stage, truncating, saturating.
// Depends on lci_pkg.
module lci_div import lci_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [N_W-1:0]     num,
  input  logic [AI_W-1:0]           den,
  output logic signed [COORD_W-1:0] coord
);
  logic [QUO_W-1:0] mag_r [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic [AI_W-1:0]  rem_r [QUO_W+1];
  logic [AI_W-1:0]  den_r [QUO_W+1];
  logic             sgn_r [QUO_W+1];
  logic signed [COORD_W-1:0] coord_r;
  logic [N_W-1:0] abs_w;

  assign abs_w = num[N_W-1] ? $unsigned(-num) : $unsigned(num);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= abs_w[QUO_W-1:0];
      quo_r[0] <= '0;
      rem_r[0] <= '0;
      den_r[0] <= den;
      sgn_r[0] <= num[N_W-1];
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [AI_W:0] sh;
    logic          ge;
    logic [AI_W:0] sub;
    assign sh  = {rem_r[j], mag_r[j][QUO_W-1]};
    assign ge  = sh >= {1'b0, den_r[j]};
    assign sub = sh - {1'b0, den_r[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[j+1] <= mag_r[j] << 1;
        quo_r[j+1] <= {quo_r[j][QUO_W-2:0], ge};
        rem_r[j+1] <= ge ? sub[AI_W-1:0] : sh[AI_W-1:0];
        den_r[j+1] <= den_r[j];
        sgn_r[j+1] <= sgn_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!sgn_r[QUO_W]) begin
        if (quo_r[QUO_W] > QUO_W'(COORD_MAX_MAG))
          coord_r <= COORD_W'(COORD_MAX_MAG);
        else
          coord_r <= quo_r[QUO_W][COORD_W-1:0];
      end else begin
        if (quo_r[QUO_W] > QUO_W'(COORD_MIN_MAG))
          coord_r <= COORD_W'(COORD_MIN_MAG);
        else
          coord_r <= ~quo_r[QUO_W][COORD_W-1:0] + 1'b1;
      end
    end
  end

  assign coord = coord_r;
endmodule

[src/lci_back.sv]
// Back pipeline: square root one bit per stage, numerators, four dividers.
// Depends on lci_pkg and lci_div.
module lci_back import lci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  mid_item_t in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam int L = Q_W + 2 + DIV_LAT;

  logic   v_r   [L];
  count_t cnt_r [L];

  logic [REM_W-1:0]      rem_r  [Q_W+1];
  logic [Q_W-1:0]        root_r [Q_W+1];
  logic [E_W-1:0]        e_r    [Q_W+1];
  logic signed [15:0]    sa_r   [Q_W+1];
  logic signed [15:0]    sb_r   [Q_W+1];
  logic [AI_W-1:0]       ai_r   [Q_W+1];
  logic signed [P_W-1:0] p_r    [Q_W+1];

  logic signed [N_W-1:0] nx1_r, ny1_r, nx2_r, ny2_r;
  logic [AI_W-1:0] ai_n_r;
  logic signed [COORD_W-1:0] x1_w, y1_w, x2_w, y2_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < L; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r[0] <= in_item.cnt;
      for (int i = 1; i < L; i++) cnt_r[i] <= cnt_r[i-1];
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      e_r[0]    <= in_item.e;
      sa_r[0]   <= in_item.sa;
      sb_r[0]   <= in_item.sb;
      ai_r[0]   <= in_item.ai;
      p_r[0]    <= in_item.p;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_sqrt
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    assign sh    = {rem_r[k][REM_W-3:0], e_r[k][E_W-1 -: 2]};
    assign trial = REM_W'({root_r[k], 2'b01});
    assign ge    = sh >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? sh - trial : sh;
        root_r[k+1] <= {root_r[k][Q_W-2:0], ge};
        e_r[k+1]    <= e_r[k] << 2;
        sa_r[k+1]   <= sa_r[k];
        sb_r[k+1]   <= sb_r[k];
        ai_r[k+1]   <= ai_r[k];
        p_r[k+1]    <= p_r[k];
      end
    end
  end

  logic signed [Q_W:0]   qs_w;
  logic signed [50:0]    saq_w;
  logic signed [N_W-1:0] qn_w, pn_w, yb_w, saqn_w;

  always_comb begin
    qs_w   = $signed({1'b0, root_r[Q_W]});
    saq_w  = sa_r[Q_W] * qs_w;
    qn_w   = N_W'(qs_w);
    pn_w   = N_W'(p_r[Q_W]);
    saqn_w = N_W'(saq_w);
    yb_w   = N_W'(sb_r[Q_W]) <<< (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1_r  <= (qn_w - pn_w) <<< FRAC_BITS;
      nx2_r  <= (-qn_w - pn_w) <<< FRAC_BITS;
      ny1_r  <= yb_w + saqn_w;
      ny2_r  <= yb_w - saqn_w;
      ai_n_r <= ai_r[Q_W];
    end
  end

  lci_div u_div_x1 (.clk(clk), .en(en), .num(nx1_r), .den(ai_n_r), .coord(x1_w));
  lci_div u_div_y1 (.clk(clk), .en(en), .num(ny1_r), .den(ai_n_r), .coord(y1_w));
  lci_div u_div_x2 (.clk(clk), .en(en), .num(nx2_r), .den(ai_n_r), .coord(x2_w));
  lci_div u_div_y2 (.clk(clk), .en(en), .num(ny2_r), .den(ai_n_r), .coord(y2_w));

  always_comb begin
    out_item.cnt = cnt_r[L-1];
    out_item.x1  = (cnt_r[L-1] == CNT_NONE) ? '0 : x1_w;
    out_item.y1  = (cnt_r[L-1] == CNT_NONE) ? '0 : y1_w;
    out_item.x2  = (cnt_r[L-1] == CNT_SECANT) ? x2_w : '0;
    out_item.y2  = (cnt_r[L-1] == CNT_SECANT) ? y2_w : '0;
  end

  assign out_valid = v_r[L-1];
endmodule

[src/line_circle_intersection_core.sv]
// Line/circle intersection core: for y = a*x + b against a circle of radius r at
// the origin, returns 0, 1 or 2 points in signed Q9.8, one result per query.
// One query is accepted per cycle while full is low, and one result delivered per
// cycle while empty is low. The accepting edge loads the first of six front stages;
// then the middle queue is written; 88 back stages follow (the back input register,
// one square-root stage per root bit, the numerators, the divider input register,
// one divider stage per quotient bit and the divider output); the result queue is
// written last.
// The front and back pipelines stall independently through a 4-entry queue.
// Depends on lci_pkg, lci_front, lci_fifo, lci_back and the defines header.
`include "line_circle_intersection_core_defines.svh"
module line_circle_intersection_core import lci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic signed [15:0]        in_slope,
  input  logic signed [15:0]        in_intercept,
  input  logic [15:0]               in_radius,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                out_point_count,
  output logic signed [COORD_W-1:0] out_first_x,
  output logic signed [COORD_W-1:0] out_first_y,
  output logic signed [COORD_W-1:0] out_second_x,
  output logic signed [COORD_W-1:0] out_second_y
);
  logic      front_adv, front_valid, mid_full, mid_empty, mid_pop;
  logic      back_en, back_valid, res_full;
  mid_item_t front_item, mid_item;
  out_item_t back_item, res_item;

  assign front_adv = !mid_full;
  assign full      = mid_full;
  assign back_en   = !res_full;
  assign mid_pop   = back_en && !mid_empty;

  lci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(front_adv), .in_valid(push),
    .in_sa(in_slope), .in_sb(in_intercept), .in_rr(in_radius),
    .out_valid(front_valid), .out_item(front_item)
  );

  lci_fifo #(.W($bits(mid_item_t)), .DEPTH(4)) u_mid_q (
    .clk(clk), .rst_n(rst_n), .push(front_adv && front_valid), .wdata(front_item),
    .full(mid_full), .pop(mid_pop), .rdata(mid_item), .empty(mid_empty)
  );

  lci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(back_en), .in_valid(mid_pop), .in_item(mid_item),
    .out_valid(back_valid), .out_item(back_item)
  );

  lci_fifo #(.W($bits(out_item_t)), .DEPTH(2)) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(back_en && back_valid), .wdata(back_item),
    .full(res_full), .pop(pop), .rdata(res_item), .empty(empty)
  );

  assign out_point_count = res_item.cnt;
  assign out_first_x     = res_item.x1;
  assign out_first_y     = res_item.y1;
  assign out_second_x    = res_item.x2;
  assign out_second_y    = res_item.y2;

  `LCI_CHECK(a_none_zero, !empty && res_item.cnt == CNT_NONE, res_item[4*COORD_W-1:0] == '0)
  `LCI_CHECK(a_tangent_zero, !empty && res_item.cnt == CNT_TANGENT, res_item[2*COORD_W-1:0] == '0)
  `LCI_CHECK_NEXT(a_reset_clear, !rst_n, empty && !full)
endmodule

[bench/tb_line_circle_intersection_core.sv]
`timescale 1ns / 100ps
// Testbench for line_circle_intersection_core: random and directed line/circle queries
// checked beat by beat against an in-bench fixed-point predictor; needs lci_pkg and the DUT.
module tb_line_circle_intersection_core;
  import lci_pkg::*;

  localparam int FB = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int N_RANDOM = 1330;
  localparam int CALM_TAIL = 150;

  typedef struct {
    logic signed [15:0] slope;
    logic signed [15:0] intercept;
    logic [15:0]        radius;
  } query_t;

  typedef struct {
    logic [1:0]                cnt;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } points_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [15:0] in_slope = '0;
  logic signed [15:0] in_intercept = '0;
  logic [15:0] in_radius = '0;
  logic full, empty;
  logic [1:0] out_point_count;
  logic signed [COORD_W-1:0] out_first_x, out_first_y, out_second_x, out_second_y;

  query_t  pending_q[$];
  points_t expected_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      in_idle = 0;
  int      out_idle = 0;
  bit      stim_done = 0;

  line_circle_intersection_core u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_slope(in_slope), .in_intercept(in_intercept), .in_radius(in_radius),
    .empty(empty), .pop(pop), .out_point_count(out_point_count),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_second_x(out_second_x), .out_second_y(out_second_y)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(logic signed [127:0] v);
    if (v < -128'sd65536) return -17'sd65536;
    if (v > 128'sd65535) return 17'sd65535;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [127:0] root_floor(logic [127:0] e);
    logic [127:0] res, t;
    res = '0;
    for (int i = 35; i >= 0; i--) begin
      t = res | (128'd1 << i);
      if (t * t <= e) res = t;
    end
    return res;
  endfunction

  function automatic points_t solve_points(query_t qy);
    points_t r;
    logic signed [127:0] sa, sb, rr, ai, p, pos, neg, e, q, yb, sc;
    sa = qy.slope;
    sb = qy.intercept;
    rr = $signed({112'd0, qy.radius});
    sc = 128'sd1 <<< FB;
    ai = sa * sa + (sc * sc);
    p = sa * sb;
    pos = ai * rr * rr;
    neg = sb * sb * sc * sc;
    r = '{CNT_NONE, '0, '0, '0, '0};
    if (neg > pos) return r;
    e = pos - neg;
    q = $signed(root_floor(e));
    yb = sb * sc * sc;
    r.x1 = clamp_coord((sc * (q - p)) / ai);
    r.y1 = clamp_coord((yb + sa * q) / ai);
    if (e == 0) begin
      r.cnt = CNT_TANGENT;
      return r;
    end
    r.cnt = CNT_SECANT;
    r.x2 = clamp_coord((sc * (-q - p)) / ai);
    r.y2 = clamp_coord((yb - sa * q) / ai);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic add_query(int s, int b, int r);
    query_t qy;
    qy.slope = s[15:0];
    qy.intercept = b[15:0];
    qy.radius = r[15:0];
    pending_q.push_back(qy);
  endtask

  // driver
  always @(posedge clk) begin
    query_t qy;
    if (rst_n) begin
      if (push && !full) begin
        qy = pending_q.pop_front();
        expected_q.push_back(solve_points(qy));
      end
      if (in_idle > 0) in_idle--;
      else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
        in_idle = $urandom_range(1, 10);
      if (in_idle == 0 && pending_q.size() > 0) begin
        push <= 1'b1;
        in_slope <= pending_q[0].slope;
        in_intercept <= pending_q[0].intercept;
        in_radius <= pending_q[0].radius;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    points_t w;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result beat at cycle %0d", cycles);
          errors++;
        end else begin
          w = expected_q.pop_front();
          if (out_point_count !== w.cnt) report_mismatch("count", out_point_count, w.cnt);
          if (out_first_x !== w.x1) report_mismatch("first_x", out_first_x, w.x1);
          if (out_first_y !== w.y1) report_mismatch("first_y", out_first_y, w.y1);
          if (out_second_x !== w.x2) report_mismatch("second_x", out_second_x, w.x2);
          if (out_second_y !== w.y2) report_mismatch("second_y", out_second_y, w.y2);
        end
      end
      if (out_idle > 0) out_idle--;
      else if (!stim_done && $urandom_range(0, 7) == 0) out_idle = $urandom_range(1, 10);
      pop <= (out_idle == 0);
    end
  end

  initial begin
    int s, b, r, k;
    add_query(0, 0, 0);
    add_query(0, 0, 65535);
    add_query(-32768, -32768, 65535);
    add_query(32767, 32767, 65535);
    add_query(-32768, 32767, 0);
    add_query(32767, -32768, 1);
    add_query(1000, 0, 0);
    add_query(256, 100, 0);
    add_query(0, 512, 512);
    add_query(0, -512, 512);
    add_query(0, 32767, 32767);
    add_query(0, 600, 512);
    add_query(256, 0, 256);
    add_query(-256, 128, 1024);
    add_query(32767, 0, 65535);
    add_query(-32768, 0, 65535);
    add_query(0, -32768, 32768);
    add_query(100, 20000, 300);
    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(0, 9);
      r = $urandom_range(0, 65535);
      if (k < 2) begin
        s = $urandom_range(0, 65535) - 32768;
        b = $urandom_range(0, 65535) - 32768;
      end else if (k == 2) begin
        s = 0;
        r = $urandom_range(0, 32768);
        b = $urandom_range(0, 1) ? r : -r;
        if (b > 32767) b = 32767;
      end else if (k == 3) begin
        s = $urandom_range(0, 65535) - 32768;
        b = 0;
        r = $urandom_range(0, 1) ? 0 : r;
      end else begin
        s = $urandom_range(0, 2047) - 1024;
        r = $urandom_range(1, 32767);
        b = $urandom_range(0, 2 * r) - r;
      end
      add_query(s, b, r);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !push);
    stim_done = 1;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0 && empty) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/lci_pkg.sv
src/lci_fifo.sv
src/lci_front.sv
src/lci_div.sv
src/lci_back.sv
src/line_circle_intersection_core.sv
bench/tb_line_circle_intersection_core.sv
